// File: rtl/slm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slm_pkg;

   // Field and store widths
   localparam int SAMPLE_W    = 16;
   localparam int OUT_W       = 16;
   localparam int CNT_W       = 11;
   localparam int RANK_W      = 10;
   localparam int MIN_SAMPLES = 4;
   localparam int MAX_SAMPLES = 1024;
   localparam int SUM_W       = 64;
   localparam int MUL_W       = 33;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int DVD_W       = 80;
   localparam int DEN_W       = 64;
   localparam int QUO_W       = 18;
   localparam int DCNT_W      = 7;
   localparam int STEP_W      = 4;

   // Reciprocal of three, applied as (v * RECIP3) >> 33, exact for v < 2^32
   localparam logic signed [MUL_W-1:0] RECIP3 = 33'sh0_AAAA_AAAB;
   localparam int RECIP3_SHIFT = 33;

   localparam logic [STEP_W-1:0] SAMPLE_LAST = 4'd12;
   localparam logic [STEP_W-1:0] FIN_LAST    = 4'd14;

   typedef enum logic [4:0] {
      MUL_NONE, MUL_LL, MUL_RR, MUL_IR, MUL_L3, MUL_R3, MUL_DL, MUL_DR,
      MUL_A, MUL_B, MUL_X2, MUL_X3, MUL_X4, MUL_D1, MUL_D2L, MUL_D2H,
      MUL_NN, MUL_D4L, MUL_D4H
   } mul_op_type;

   typedef enum logic [1:0] {
      FLD_MEAN, FLD_CV, FLD_SKEW, FLD_KURT
   } field_type;

   typedef enum logic [1:0] {
      STAT_OK, STAT_MEAN_ZERO, STAT_L2_ZERO, STAT_SAT
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SAMPLE, S_FINAL, S_DIVWAIT, S_EMIT
   } state_type;

   typedef struct packed {
      mul_op_type mul_op;
      logic       load_x;
      logic       next_rank;
      logic       clear_run;
      logic       div_start;
      field_type  fld;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic div_done;
      logic rsp_busy;
   } stat_type;

   typedef struct packed {
      mul_op_type mul_op;
      logic       div_start;
      field_type  fld;
   } fin_type;

   // Per-sample weight and accumulate sequence
   function automatic mul_op_type sample_op(input logic [STEP_W-1:0] step);
      mul_op_type op;
      case (step)
         4'd0:    op = MUL_LL;
         4'd1:    op = MUL_RR;
         4'd2:    op = MUL_IR;
         4'd3:    op = MUL_L3;
         4'd4:    op = MUL_R3;
         4'd5:    op = MUL_DL;
         4'd6:    op = MUL_DR;
         4'd7:    op = MUL_A;
         4'd8:    op = MUL_B;
         4'd9:    op = MUL_X2;
         4'd10:   op = MUL_X3;
         4'd11:   op = MUL_X4;
         default: op = MUL_NONE;
      endcase
      return op;
   endfunction

   // End-of-run denominator and division sequence
   function automatic fin_type fin_op(input logic [STEP_W-1:0] step);
      fin_type f;
      f.mul_op    = MUL_NONE;
      f.div_start = 1'b0;
      f.fld       = FLD_MEAN;
      case (step)
         4'd0:    begin f.div_start = 1'b1; f.fld = FLD_MEAN; end
         4'd1:    f.mul_op = MUL_D1;
         4'd3:    begin f.div_start = 1'b1; f.fld = FLD_CV; end
         4'd4:    f.mul_op = MUL_D2L;
         4'd5:    f.mul_op = MUL_D2H;
         4'd7:    begin f.div_start = 1'b1; f.fld = FLD_SKEW; end
         4'd8:    f.mul_op = MUL_NN;
         4'd10:   f.mul_op = MUL_D4L;
         4'd11:   f.mul_op = MUL_D4H;
         4'd13:   begin f.div_start = 1'b1; f.fld = FLD_KURT; end
         default: f.mul_op = MUL_NONE;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

// File: rtl/sample_l_moments.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                  Handshake
// request   req_sample                             req_valid / req_ready
// result    rsp_l_mean, rsp_l_cv, rsp_l_skew,      rsp_valid / rsp_ready
//           rsp_l_kurt, rsp_status
// csr       csr_wr_data (run length)               csr_wr_en, no wait
//
// Each sample is taken in one transfer, then passes 13 steps of the one
// shared 33x33 multiplier that builds the rank weights and accumulates.
// After the last sample of a run come four 80-step restoring divisions
// plus denominator products, then one result transfer.
// Reset is synchronous and clears the run; run length resets to 4.
// A stalled result sits in the output register; the next run may start,
// and only its own result waits for that transfer.
module sample_l_moments (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [slm_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [slm_pkg::OUT_W-1:0]         rsp_l_mean,
   output logic signed [slm_pkg::OUT_W-1:0]         rsp_l_cv,
   output logic signed [slm_pkg::OUT_W-1:0]         rsp_l_skew,
   output logic signed [slm_pkg::OUT_W-1:0]         rsp_l_kurt,
   output logic [1:0]                               rsp_status,
   input  wire logic                                csr_wr_en,
   input  wire logic [slm_pkg::CNT_W-1:0]           csr_wr_data
);

   slm_pkg::cmd_type  cmd;
   slm_pkg::stat_type stat;

   slm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   slm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_l_mean  (rsp_l_mean),
      .rsp_l_cv    (rsp_l_cv),
      .rsp_l_skew  (rsp_l_skew),
      .rsp_l_kurt  (rsp_l_kurt),
      .rsp_status  (rsp_status)
   );

endmodule

`default_nettype wire

// File: rtl/slm_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle; only the low quotient
// bits are kept, anything above them sets a sticky overflow flag.
module slm_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [slm_pkg::DVD_W-1:0]       dividend,
   input  wire logic [slm_pkg::DEN_W-1:0]       divisor,
   output logic                                 busy,
   output logic                                 done,
   output logic [slm_pkg::QUO_W-1:0]            quot,
   output logic                                 big
);

   logic                          busy_ff, done_ff, big_ff;
   logic [slm_pkg::DCNT_W-1:0]    cnt_ff;
   logic [slm_pkg::DVD_W-1:0]     dvd_ff;
   logic [slm_pkg::DEN_W-1:0]     den_ff, rem_ff, rem_in;
   logic [slm_pkg::QUO_W-1:0]     q_ff;
   logic [slm_pkg::DEN_W:0]       trial;
   logic                          qbit;

   // Trial subtract
   always_comb begin
      trial = {rem_ff, dvd_ff[slm_pkg::DVD_W-1]};
      qbit  = (trial >= {1'b0, den_ff});
      rem_in = qbit ? slm_pkg::DEN_W'(trial - {1'b0, den_ff})
                    : trial[slm_pkg::DEN_W-1:0];
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == slm_pkg::DCNT_W'(slm_pkg::DVD_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         rem_ff <= '0;
         dvd_ff <= dividend;
         den_ff <= divisor;
         q_ff   <= '0;
         big_ff <= 1'b0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         rem_ff <= rem_in;
         dvd_ff <= dvd_ff << 1;
         q_ff   <= {q_ff[slm_pkg::QUO_W-2:0], qbit};
         big_ff <= big_ff | q_ff[slm_pkg::QUO_W-1];
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;
   assign big  = big_ff;

endmodule

`default_nettype wire

// File: rtl/slm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module slm_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire slm_pkg::cmd_type                    cmd,
   output slm_pkg::stat_type                        stat,
   input  wire logic                                csr_wr_en,
   input  wire logic [slm_pkg::CNT_W-1:0]           csr_wr_data,
   input  wire logic signed [slm_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [slm_pkg::OUT_W-1:0]         rsp_l_mean,
   output logic signed [slm_pkg::OUT_W-1:0]         rsp_l_cv,
   output logic signed [slm_pkg::OUT_W-1:0]         rsp_l_skew,
   output logic signed [slm_pkg::OUT_W-1:0]         rsp_l_kurt,
   output logic [1:0]                               rsp_status
);

   localparam int W = slm_pkg::MUL_W;

   logic [slm_pkg::CNT_W-1:0]           cnt_ff, n;
   logic [slm_pkg::RANK_W-1:0]          rank_ff, cr;
   logic signed [slm_pkg::SAMPLE_W-1:0] x_ff;
   logic [18:0]                         cl2_ff, cr2_ff;
   logic [17:0]                         c_ff;
   logic [29:0]                         cl3_ff, cr3_ff, a_ff, b_ff;
   logic [19:0]                         mm_ff;
   logic [slm_pkg::DEN_W-1:0]           den_ff;
   logic signed [slm_pkg::PROD_W-1:0]   prod_ff;
   slm_pkg::mul_op_type                 op_d_ff;
   logic [slm_pkg::SUM_W-1:0]           s1_ff, s2_ff, s3_ff, s4_ff;
   logic [slm_pkg::SUM_W-1:0]           s1m, s2m, s3m, s4m;
   logic signed [W-1:0]                 mul_a, mul_b;
   logic signed [W-1:0]                 i_s, cr_s, n_s, x_s, w2_s, w3_s, w4_s;
   logic                                s1zero, s2zero;

   // Division hand-off
   logic [slm_pkg::DVD_W-1:0]           dvd;
   logic [slm_pkg::DEN_W-1:0]           dvs;
   logic                                neg_in, neg_ff;
   slm_pkg::field_type                  fld_ff;
   logic                                div_busy, div_done, div_big;
   logic [slm_pkg::QUO_W-1:0]           div_q;
   logic [slm_pkg::QUO_W:0]             q_inc;
   logic [slm_pkg::QUO_W-1:0]           mag;
   logic                                fsat, fzero;
   logic [slm_pkg::OUT_W-1:0]           fval;
   logic [slm_pkg::OUT_W-1:0]           mean_ff, cv_ff, skew_ff, kurt_ff;
   logic                                sat_ff;

   logic                                rsp_valid_ff;
   logic [slm_pkg::OUT_W-1:0]           o_mean_ff, o_cv_ff, o_skew_ff, o_kurt_ff;
   slm_pkg::status_type                 o_status_ff, status_in;

   // Run length, clamped
   always_comb begin
      if (cnt_ff < slm_pkg::CNT_W'(slm_pkg::MIN_SAMPLES))
         n = slm_pkg::CNT_W'(slm_pkg::MIN_SAMPLES);
      else if (cnt_ff > slm_pkg::CNT_W'(slm_pkg::MAX_SAMPLES))
         n = slm_pkg::CNT_W'(slm_pkg::MAX_SAMPLES);
      else
         n = cnt_ff;
      cr = slm_pkg::RANK_W'(n - 1'b1 - {1'b0, rank_ff});
   end

   // Weights and magnitudes
   always_comb begin
      i_s  = $signed(W'(rank_ff));
      cr_s = $signed(W'(cr));
      n_s  = $signed(W'(n));
      x_s  = W'(x_ff);
      w2_s = i_s - cr_s;
      w3_s = $signed(W'(cl2_ff)) - $signed(W'({c_ff, 1'b0})) + $signed(W'(cr2_ff));
      w4_s = $signed(W'(cl3_ff)) - 3 * $signed(W'(a_ff)) + 3 * $signed(W'(b_ff))
             - $signed(W'(cr3_ff));
      s1m = s1_ff[slm_pkg::SUM_W-1] ? (~s1_ff + 1'b1) : s1_ff;
      s2m = s2_ff[slm_pkg::SUM_W-1] ? (~s2_ff + 1'b1) : s2_ff;
      s3m = s3_ff[slm_pkg::SUM_W-1] ? (~s3_ff + 1'b1) : s3_ff;
      s4m = s4_ff[slm_pkg::SUM_W-1] ? (~s4_ff + 1'b1) : s4_ff;
      s1zero = (s1_ff == '0);
      s2zero = (s2_ff == '0);
   end

   // Shared multiplier operand select
   always_comb begin
      case (cmd.mul_op)
         slm_pkg::MUL_LL:  begin mul_a = i_s;                   mul_b = i_s - W'(1); end
         slm_pkg::MUL_RR:  begin mul_a = cr_s;                  mul_b = cr_s - W'(1); end
         slm_pkg::MUL_IR:  begin mul_a = i_s;                   mul_b = cr_s; end
         slm_pkg::MUL_L3:  begin mul_a = $signed(W'(cl2_ff));   mul_b = i_s - W'(2); end
         slm_pkg::MUL_R3:  begin mul_a = $signed(W'(cr2_ff));   mul_b = cr_s - W'(2); end
         slm_pkg::MUL_DL:  begin mul_a = $signed(W'(cl3_ff));   mul_b = slm_pkg::RECIP3; end
         slm_pkg::MUL_DR:  begin mul_a = $signed(W'(cr3_ff));   mul_b = slm_pkg::RECIP3; end
         slm_pkg::MUL_A:   begin mul_a = $signed(W'(cl2_ff));   mul_b = cr_s; end
         slm_pkg::MUL_B:   begin mul_a = i_s;                   mul_b = $signed(W'(cr2_ff)); end
         slm_pkg::MUL_X2:  begin mul_a = w2_s;                  mul_b = x_s; end
         slm_pkg::MUL_X3:  begin mul_a = w3_s;                  mul_b = x_s; end
         slm_pkg::MUL_X4:  begin mul_a = w4_s;                  mul_b = x_s; end
         slm_pkg::MUL_D1:  begin mul_a = n_s - W'(1);           mul_b = $signed(W'(s1m[31:0])); end
         slm_pkg::MUL_D2L: begin mul_a = n_s - W'(2);           mul_b = $signed(W'(s2m[31:0])); end
         slm_pkg::MUL_D2H: begin mul_a = n_s - W'(2);           mul_b = $signed(W'(s2m[63:32])); end
         slm_pkg::MUL_NN:  begin mul_a = n_s - W'(2);           mul_b = n_s - W'(3); end
         slm_pkg::MUL_D4L: begin mul_a = $signed(W'(mm_ff));    mul_b = $signed(W'(s2m[31:0])); end
         slm_pkg::MUL_D4H: begin mul_a = $signed(W'(mm_ff));    mul_b = $signed(W'(s2m[63:32])); end
         default:          begin mul_a = '0;                    mul_b = '0; end
      endcase
   end

   // Product register and write-back in the following cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         op_d_ff <= slm_pkg::MUL_NONE;
      end else begin
         op_d_ff <= cmd.mul_op;
      end
      prod_ff <= mul_a * mul_b;
      case (op_d_ff)
         slm_pkg::MUL_LL:  cl2_ff <= prod_ff[19:1];
         slm_pkg::MUL_RR:  cr2_ff <= prod_ff[19:1];
         slm_pkg::MUL_IR:  c_ff   <= prod_ff[17:0];
         slm_pkg::MUL_L3:  cl3_ff <= prod_ff[29:0];
         slm_pkg::MUL_R3:  cr3_ff <= prod_ff[29:0];
         slm_pkg::MUL_DL:  cl3_ff <= prod_ff[slm_pkg::RECIP3_SHIFT +: 30];
         slm_pkg::MUL_DR:  cr3_ff <= prod_ff[slm_pkg::RECIP3_SHIFT +: 30];
         slm_pkg::MUL_A:   a_ff   <= prod_ff[29:0];
         slm_pkg::MUL_B:   b_ff   <= prod_ff[29:0];
         slm_pkg::MUL_D1,
         slm_pkg::MUL_D2L,
         slm_pkg::MUL_D4L: den_ff <= prod_ff[63:0];
         slm_pkg::MUL_D2H,
         slm_pkg::MUL_D4H: den_ff <= den_ff + {prod_ff[31:0], 32'b0};
         slm_pkg::MUL_NN:  mm_ff  <= prod_ff[19:0];
         default:          ;
      endcase
      if (cmd.load_x)
         x_ff <= req_sample;
   end

   // Run state: register, rank, sums, saturation flag
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= slm_pkg::CNT_W'(slm_pkg::MIN_SAMPLES);
      end else if (csr_wr_en) begin
         cnt_ff <= csr_wr_data;
      end
      if (reset || csr_wr_en || cmd.clear_run) begin
         rank_ff <= '0;
         s1_ff   <= '0;
         s2_ff   <= '0;
         s3_ff   <= '0;
         s4_ff   <= '0;
         sat_ff  <= 1'b0;
      end else begin
         if (cmd.load_x)
            s1_ff <= s1_ff + slm_pkg::SUM_W'(req_sample);
         if (cmd.next_rank)
            rank_ff <= rank_ff + 1'b1;
         case (op_d_ff)
            slm_pkg::MUL_X2: s2_ff <= s2_ff + prod_ff[63:0];
            slm_pkg::MUL_X3: s3_ff <= s3_ff + prod_ff[63:0];
            slm_pkg::MUL_X4: s4_ff <= s4_ff + prod_ff[63:0];
            default:         ;
         endcase
         if (div_done && fsat && !fzero)
            sat_ff <= 1'b1;
      end
   end

   // Dividend, divisor and quotient sign per field
   always_comb begin
      case (cmd.fld)
         slm_pkg::FLD_MEAN: begin
            dvd    = slm_pkg::DVD_W'(s1m) << 1;
            dvs    = slm_pkg::DEN_W'(n);
            neg_in = s1_ff[63];
         end
         slm_pkg::FLD_CV: begin
            dvd    = slm_pkg::DVD_W'(s2m) << 13;
            dvs    = den_ff;
            neg_in = s2_ff[63] ^ s1_ff[63];
         end
         slm_pkg::FLD_SKEW: begin
            dvd    = slm_pkg::DVD_W'(s3m) << 14;
            dvs    = den_ff;
            neg_in = s3_ff[63] ^ s2_ff[63];
         end
         default: begin
            dvd    = (slm_pkg::DVD_W'(s4m) << 15) + (slm_pkg::DVD_W'(s4m) << 14);
            dvs    = den_ff;
            neg_in = s4_ff[63] ^ s2_ff[63];
         end
      endcase
   end

   slm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_q),
      .big      (div_big)
   );

   // Round half up, saturate, zero-case masking
   always_comb begin
      q_inc = {1'b0, div_q} + 1'b1;
      mag   = q_inc[slm_pkg::QUO_W:1];
      fsat  = div_big || (neg_ff ? (mag > 18'd32768) : (mag > 18'd32767));
      if (fsat)
         fval = neg_ff ? 16'h8000 : 16'h7FFF;
      else
         fval = neg_ff ? slm_pkg::OUT_W'(~mag + 1'b1) : mag[slm_pkg::OUT_W-1:0];
      fzero = ((fld_ff == slm_pkg::FLD_CV) && s1zero) ||
              (((fld_ff == slm_pkg::FLD_SKEW) || (fld_ff == slm_pkg::FLD_KURT)) && s2zero);
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         fld_ff <= cmd.fld;
         neg_ff <= neg_in;
      end
      if (div_done) begin
         case (fld_ff)
            slm_pkg::FLD_MEAN: mean_ff <= fval;
            slm_pkg::FLD_CV:   cv_ff   <= fzero ? '0 : fval;
            slm_pkg::FLD_SKEW: skew_ff <= fzero ? '0 : fval;
            default:           kurt_ff <= fzero ? '0 : fval;
         endcase
      end
   end

   // Status code
   always_comb begin
      if (s1zero)      status_in = slm_pkg::STAT_MEAN_ZERO;
      else if (s2zero) status_in = slm_pkg::STAT_L2_ZERO;
      else if (sat_ff) status_in = slm_pkg::STAT_SAT;
      else             status_in = slm_pkg::STAT_OK;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         o_mean_ff   <= mean_ff;
         o_cv_ff     <= cv_ff;
         o_skew_ff   <= skew_ff;
         o_kurt_ff   <= kurt_ff;
         o_status_ff <= status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_l_mean    = o_mean_ff;
   assign rsp_l_cv      = o_cv_ff;
   assign rsp_l_skew    = o_skew_ff;
   assign rsp_l_kurt    = o_kurt_ff;
   assign rsp_status    = o_status_ff;
   assign stat.last     = ({1'b0, rank_ff} + 1'b1 == n);
   assign stat.div_done = div_done;
   assign stat.rsp_busy = rsp_valid_ff;

   // Checks
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff) else $error("result loaded over pending transfer");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy) else $error("divider restarted while busy");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_run |=> (rank_ff == '0 && s1_ff == '0)) else $error("run not cleared");

endmodule

`default_nettype wire

// File: rtl/slm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module slm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output slm_pkg::cmd_type       cmd,
   input  wire slm_pkg::stat_type stat
);

   slm_pkg::state_type           state_ff, state_in;
   logic [slm_pkg::STEP_W-1:0]   step_ff, step_in;
   slm_pkg::fin_type             fin;

   assign fin = slm_pkg::fin_op(step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slm_pkg::S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         slm_pkg::S_IDLE: begin
            step_in = '0;
            if (req_valid)
               state_in = slm_pkg::S_SAMPLE;
         end
         slm_pkg::S_SAMPLE: begin
            if (step_ff == slm_pkg::SAMPLE_LAST) begin
               step_in  = '0;
               state_in = stat.last ? slm_pkg::S_FINAL : slm_pkg::S_IDLE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         slm_pkg::S_FINAL: begin
            step_in = step_ff + 1'b1;
            if (step_ff == slm_pkg::FIN_LAST)
               state_in = slm_pkg::S_EMIT;
            else if (fin.div_start)
               state_in = slm_pkg::S_DIVWAIT;
         end
         slm_pkg::S_DIVWAIT: begin
            if (stat.div_done)
               state_in = slm_pkg::S_FINAL;
         end
         slm_pkg::S_EMIT: begin
            if (!stat.rsp_busy)
               state_in = slm_pkg::S_IDLE;
         end
         default: state_in = slm_pkg::S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      cmd.fld   = slm_pkg::FLD_MEAN;
      cmd.mul_op = slm_pkg::MUL_NONE;
      req_ready = 1'b0;
      case (state_ff)
         slm_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.load_x = req_valid;
         end
         slm_pkg::S_SAMPLE: begin
            cmd.mul_op    = slm_pkg::sample_op(step_ff);
            cmd.next_rank = (step_ff == slm_pkg::SAMPLE_LAST) && !stat.last;
         end
         slm_pkg::S_FINAL: begin
            cmd.mul_op    = fin.mul_op;
            cmd.div_start = fin.div_start;
            cmd.fld       = fin.fld;
         end
         slm_pkg::S_EMIT: begin
            cmd.out_load  = !stat.rsp_busy;
            cmd.clear_run = !stat.rsp_busy;
         end
         default: ;
      endcase
   end

   // Checks
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == slm_pkg::S_IDLE) else $error("ready outside idle");
   a_wait_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == slm_pkg::S_DIVWAIT && stat.div_done) |=> state_ff == slm_pkg::S_FINAL)
      else $error("missed division completion");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   // One run result as seen on the rsp_ ports
   typedef struct {
      logic signed [slm_pkg::OUT_W-1:0] mean;
      logic signed [slm_pkg::OUT_W-1:0] cv;
      logic signed [slm_pkg::OUT_W-1:0] skew;
      logic signed [slm_pkg::OUT_W-1:0] kurt;
      logic [1:0]                       status;
   } lmom_result_type;

   // Rank-weighted sums, run length and the queue of pending run results
   class lmoment_scoreboard;
      logic [63:0]     run_len;
      logic [63:0]     rank;
      logic [63:0]     s1, s2, s3, s4;
      lmom_result_type pending_runs[$];
      int              errors;

      function new();
         run_len = slm_pkg::MIN_SAMPLES;
         errors  = 0;
         clear_run();
      endfunction

      function void clear_run();
         rank = 0; s1 = 0; s2 = 0; s3 = 0; s4 = 0;
      endfunction

      function void set_length(logic [slm_pkg::CNT_W-1:0] v);
         run_len = 64'(v);
         clear_run();
      endfunction

      function logic [63:0] mag(logic [63:0] v);
         return v[63] ? (~v + 64'd1) : v;
      endfunction

      // Scaled quotient num*k/(2 den), rounded, saturated to 16 bits
      function logic [15:0] ratio(logic [63:0] num, logic [63:0] den_mag, bit den_neg,
                                  logic [63:0] k, inout bit sat);
         bit           neg;
         logic [127:0] prod;
         logic [127:0] q;
         neg = num[63] != den_neg;
         if (den_mag == 0) begin
            sat = 1;
            return neg ? 16'h8000 : 16'h7FFF;
         end
         prod = {64'd0, mag(num)} * {64'd0, k};
         q    = prod / {64'd0, den_mag};
         if (q > (128'd1 << 42)) q = 128'd1 << 42;
         q = (q + 128'd1) >> 1;
         if (neg) begin
            if (q > 128'd32768) begin sat = 1; q = 128'd32768; end
            return 16'(~q[15:0] + 16'd1);
         end
         if (q > 128'd32767) begin sat = 1; q = 128'd32767; end
         return q[15:0];
      endfunction

      // Fold one accepted sample into the sums; queue a result at run end
      function void note_sample(logic signed [slm_pkg::SAMPLE_W-1:0] smp);
         logic [63:0]     n, x, i, cr, cl2, cl3, cr2, cr3, s2m;
         bit              sat;
         lmom_result_type r;
         n = run_len;
         if (n < slm_pkg::MIN_SAMPLES) n = slm_pkg::MIN_SAMPLES;
         if (n > slm_pkg::MAX_SAMPLES) n = slm_pkg::MAX_SAMPLES;
         if (rank >= n) rank = 0;
         x   = {{48{smp[slm_pkg::SAMPLE_W-1]}}, smp};
         i   = rank;
         cr  = n - 64'd1 - i;
         cl2 = i * (i - 64'd1) / 64'd2;
         cl3 = cl2 * (i - 64'd2) / 64'd3;
         cr2 = cr * (cr - 64'd1) / 64'd2;
         cr3 = cr2 * (cr - 64'd2) / 64'd3;
         s1 += x;
         s2 += (i - cr) * x;
         s3 += (cl2 - 64'd2 * i * cr + cr2) * x;
         s4 += (cl3 - 64'd3 * cl2 * cr + 64'd3 * i * cr2 - cr3) * x;
         if (i + 64'd1 < n) begin
            rank++;
            return;
         end
         sat    = 0;
         s2m    = mag(s2);
         r.mean = ratio(s1, n, 0, 64'd2, sat);
         r.cv   = (s1 == 0) ? 16'd0
                : ratio(s2, (n - 64'd1) * mag(s1), s1[63], 64'd8192, sat);
         if (s2 == 0) begin
            r.skew = 0;
            r.kurt = 0;
         end else begin
            r.skew = ratio(s3, (n - 64'd2) * s2m, s2[63], 64'd16384, sat);
            r.kurt = ratio(s4, (n - 64'd2) * (n - 64'd3) * s2m, s2[63], 64'd49152, sat);
         end
         if (s1 == 0)      r.status = slm_pkg::STAT_MEAN_ZERO;
         else if (s2 == 0) r.status = slm_pkg::STAT_L2_ZERO;
         else if (sat)     r.status = slm_pkg::STAT_SAT;
         else              r.status = slm_pkg::STAT_OK;
         pending_runs.push_back(r);
         clear_run();
      endfunction

      task report(string what, int got, int want);
         $display("%0t: mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
         errors++;
      endtask

      task check(lmom_result_type got);
         lmom_result_type want;
         if (pending_runs.size() == 0) begin
            report("result with no run pending", 1, 0);
            return;
         end
         want = pending_runs.pop_front();
         if (got.mean != want.mean)     report("l_mean", got.mean, want.mean);
         if (got.cv != want.cv)         report("l_cv", got.cv, want.cv);
         if (got.skew != want.skew)     report("l_skew", got.skew, want.skew);
         if (got.kurt != want.kurt)     report("l_kurt", got.kurt, want.kurt);
         if (got.status != want.status) report("status", got.status, want.status);
      endtask
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic signed [slm_pkg::SAMPLE_W-1:0] req_sample;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [slm_pkg::OUT_W-1:0]    rsp_l_mean, rsp_l_cv, rsp_l_skew, rsp_l_kurt;
   logic [1:0]                          rsp_status;
   logic                                csr_wr_en;
   logic [slm_pkg::CNT_W-1:0]           csr_wr_data;

   lmoment_scoreboard sb = new();
   int send_idle_pct = 31;
   int recv_idle_pct = 71;
   int samples_sent  = 0;

   sample_l_moments u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_l_mean  (rsp_l_mean),
      .rsp_l_cv    (rsp_l_cv),
      .rsp_l_skew  (rsp_l_skew),
      .rsp_l_kurt  (rsp_l_kurt),
      .rsp_status  (rsp_status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Result monitor
   always @(posedge clock) begin
      lmom_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.mean   = rsp_l_mean;
         got.cv     = rsp_l_cv;
         got.skew   = rsp_l_skew;
         got.kurt   = rsp_l_kurt;
         got.status = rsp_status;
         sb.check(got);
      end
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   // One sample transfer; valid stays high unless the sender idles next
   task send_sample(logic signed [slm_pkg::SAMPLE_W-1:0] smp);
      req_valid  <= 1'b1;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(smp);
      samples_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   // Valid is dropped after a run
   task send_run(logic signed [slm_pkg::SAMPLE_W-1:0] run[]);
      foreach (run[k]) send_sample(run[k]);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for every pending result, then for any sample still in flight
   task drain();
      while (sb.pending_runs.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task write_length(logic [slm_pkg::CNT_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_length(v);
   endtask

   function int clamp_len(logic [slm_pkg::CNT_W-1:0] v);
      if (v < slm_pkg::MIN_SAMPLES) return slm_pkg::MIN_SAMPLES;
      if (v > slm_pkg::MAX_SAMPLES) return slm_pkg::MAX_SAMPLES;
      return v;
   endfunction

   // Random run of n samples, mostly sorted, in one of several shapes
   task random_run(int n);
      logic signed [slm_pkg::SAMPLE_W-1:0] run[];
      int shape, base, spread;
      run    = new[n];
      shape  = $urandom_range(9);
      base   = $urandom_range(65535) - 32768;
      spread = 1 << $urandom_range(15);
      foreach (run[k]) begin
         case (shape)
            0:       run[k] = 16'(base);
            1:       run[k] = 16'($urandom_range(3) - 1);
            2:       run[k] = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            3, 4:    run[k] = 16'($urandom_range(spread) + base);
            default: run[k] = 16'($urandom);
         endcase
      end
      if ($urandom_range(19) != 0) run.sort();
      send_run(run);
   endtask

   initial begin
      logic signed [slm_pkg::SAMPLE_W-1:0] run[];
      logic [slm_pkg::CNT_W-1:0] lens[];
      logic [slm_pkg::CNT_W-1:0] len;
      int phase, li, runs;

      lens        = '{5, 3, 7, 0, 12, 6, 9, 4, 16, 8};
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_sample  <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      rsp_ready   <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed runs at the reset length of four
      run = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}; send_run(run);
      run = '{0, 0, 0, 0};                                 send_run(run);
      run = '{-5, -1, 1, 5};                               send_run(run);
      run = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF}; send_run(run);
      run = '{1, 2, 3, 30000};                             send_run(run);
      run = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}; send_run(run);

      // A partial run is abandoned by a register write
      write_length(4);
      send_sample(100);
      send_sample(200);
      req_valid <= 1'b0;
      write_length(5);
      run = '{-3, -2, 0, 7, 9};                            send_run(run);

      // Random runs under three idling patterns
      li = 0;
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 71 : 0;
         recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 31 : 0;
         while (samples_sent < 170 * (phase + 1)) begin
            len = lens[li % lens.size()];
            li++;
            write_length(len);
            runs = $urandom_range(6, 2);
            repeat (runs) random_run(clamp_len(len));
            if ($urandom_range(9) == 0) begin
               repeat ($urandom_range(clamp_len(len) - 1, 1))
                  send_sample(16'($urandom));
               req_valid <= 1'b0;
            end
         end
      end

      drain();
      while (sb.pending_runs.size() != 0) begin
         sb.report("missing result", 0, 1);
         void'(sb.pending_runs.pop_front());
      end
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
